[rtl/dlvf_pkg.sv]
`timescale 1ns / 1ps

package dlvf_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned DEPTH_BITS_DEF = 16;

    localparam int unsigned RWIDTH_W    = 12;
    localparam int unsigned RCOUNT_W    = 13;
    localparam int unsigned GAIN_W      = 24;
    localparam int unsigned DEPTH_W     = 16;
    localparam int unsigned VAR_W       = 42;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned ROW_W       = 14;
    localparam int unsigned MUL_W       = 32;
    localparam int unsigned PROD_W      = 64;
    localparam int unsigned NOISE_SHIFT = 28;
    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned NTAPS       = 9;

    localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RST  = 12'd640;
    localparam logic [RCOUNT_W-1:0] ROW_COUNT_RST  = 13'd480;
    localparam logic [GAIN_W-1:0]   NOISE_GAIN_RST = 24'd122406;

    localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] REG_NOISE_GAIN = 2'd2;

    // Binomial weights 1 2 1 / 2 4 2 / 1 2 1 as left shifts.
    localparam logic [1:0] KERN_SHIFT [NTAPS] = '{
        2'd0, 2'd1, 2'd0,
        2'd1, 2'd2, 2'd1,
        2'd0, 2'd1, 2'd0
    };

    typedef struct packed {
        logic take;
        logic virt;
        logic shift;
        logic load;
        logic adv;
        logic park;
        logic var_start;
        logic out_load;
        logic out_fe;
        logic out_last;
    } dlvf_cmd_t;

    typedef struct packed {
        logic need_a;
        logic need_b;
        logic stop;
        logic drain_ok;
        logic fe_a;
        logic var_done;
        logic var_busy;
        logic out_free;
    } dlvf_stat_t;

endpackage

[rtl/dlvf_ram.sv]
`timescale 1ns / 1ps

module dlvf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/dlvf_var.sv]
`timescale 1ns / 1ps

module dlvf_var #(
    parameter int unsigned DEPTH_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start_i,
    input  logic [DEPTH_BITS-1:0]        win_i [9],
    input  logic [dlvf_pkg::GAIN_W-1:0]  gain_i,
    output logic                         busy_o,
    output logic                         done_o,
    output logic [dlvf_pkg::VAR_W-1:0]   result_o
);

    import dlvf_pkg::*;

    localparam int unsigned S1W = DEPTH_BITS + 4;
    localparam int unsigned S2W = 2 * DEPTH_BITS + 4;

    localparam logic [3:0] PH_SQ   = 4'd9;
    localparam logic [3:0] PH_HI   = 4'd10;
    localparam logic [3:0] PH_LO   = 4'd11;
    localparam logic [3:0] PH_LAST = 4'd12;

    logic [3:0]        phase_reg, phase_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [S1W-1:0]    s1_reg, s1_next;
    logic [S2W-1:0]    s2_reg, s2_next;
    logic [VAR_W-1:0]  res_reg, res_next;
    logic [MUL_W-1:0]  op_a, op_b;
    logic [PROD_W-1:0] s2_wide;
    logic [3:0]        kidx;

    assign s2_wide = PROD_W'(s2_reg);
    assign kidx    = phase_reg - 4'd1;

    // One shared multiplier: nine squares, then S1*S1, then the gain on
    // the upper and lower halves of S2.
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (phase_reg < PH_SQ) begin
            op_a = MUL_W'(win_i[phase_reg]);
            op_b = MUL_W'(win_i[phase_reg]);
        end else if (phase_reg == PH_SQ) begin
            op_a = MUL_W'(s1_reg);
            op_b = MUL_W'(s1_reg);
        end else if (phase_reg == PH_HI) begin
            op_a = s2_wide[63:32];
            op_b = MUL_W'(gain_i);
        end else if (phase_reg == PH_LO) begin
            op_a = s2_wide[31:0];
            op_b = MUL_W'(gain_i);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        res_next   = res_reg;
        if (start_i) begin
            phase_next = '0;
            busy_next  = 1'b1;
            s1_next    = '0;
            s2_next    = '0;
        end else if (busy_reg) begin
            prod_next  = PROD_W'(op_a) * PROD_W'(op_b);
            phase_next = phase_reg + 4'd1;
            if (phase_reg < PH_SQ) begin
                s1_next = s1_reg + (S1W'(win_i[phase_reg]) << KERN_SHIFT[phase_reg]);
            end
            if (phase_reg != '0 && phase_reg <= PH_SQ) begin
                s2_next = s2_reg + S2W'(prod_reg << KERN_SHIFT[kidx]);
            end
            if (phase_reg == PH_HI) begin
                res_next = VAR_W'(s2_wide << 4) - VAR_W'(prod_reg);
            end
            if (phase_reg == PH_LO) begin
                res_next = res_reg + VAR_W'(prod_reg << 4);
            end
            if (phase_reg == PH_LAST) begin
                res_next  = res_reg + VAR_W'(prod_reg >> NOISE_SHIFT);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
        prod_reg <= prod_next;
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        res_reg  <= res_next;
    end

    assign busy_o   = busy_reg;
    assign done_o   = done_reg;
    assign result_o = res_reg;

endmodule

[rtl/dlvf_dp.sv]
`timescale 1ns / 1ps

module dlvf_dp #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned DEPTH_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [dlvf_pkg::RWIDTH_W-1:0]    row_width_i,
    input  logic [dlvf_pkg::RCOUNT_W-1:0]    row_count_i,
    input  logic [dlvf_pkg::GAIN_W-1:0]      gain_i,
    input  logic                             pos_clear_i,
    input  logic [dlvf_pkg::DEPTH_W-1:0]     depth_i,
    input  dlvf_pkg::dlvf_cmd_t              cmd_i,
    output dlvf_pkg::dlvf_stat_t             stat_o,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dlvf_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast,
    output logic [0:0]                       m_tuser
);

    import dlvf_pkg::*;

    localparam int unsigned DW    = DEPTH_BITS;
    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned CW1   = COL_W + 1;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [DW-1:0]       win_reg [9];
    logic [DW-1:0]       win_next [9];
    logic [DW-1:0]       colv [3];
    logic [DW-1:0]       rd_a, rd_b, wr_b;
    logic [CW1-1:0]      eff_w;
    logic [RCOUNT_W-1:0] eff_h;
    logic [ROW_W-1:0]    h0, h1, h2;
    logic                out_valid_reg, out_valid_next;
    logic [VAR_W-1:0]    out_var_reg, out_var_next;
    logic                out_fe_reg, out_fe_next;
    logic                out_last_reg, out_last_next;
    logic [VAR_W-1:0]    var_result;
    logic                var_busy, var_done;

    always_comb begin
        if (row_width_i == '0) begin
            eff_w = CW1'(1);
        end else if (32'(row_width_i) > 32'(MAX_WIDTH)) begin
            eff_w = CW1'(MAX_WIDTH);
        end else begin
            eff_w = CW1'(row_width_i);
        end
    end

    assign eff_h = (row_count_i == '0) ? RCOUNT_W'(1) : row_count_i;
    assign h0    = ROW_W'(eff_h);
    assign h1    = h0 + ROW_W'(1);
    assign h2    = h0 + ROW_W'(2);

    always_comb begin
        stat_o          = '0;
        stat_o.need_a   = (col_reg == '0) && (row_reg >= ROW_W'(2));
        stat_o.need_b   = (col_reg != '0) && (row_reg >= ROW_W'(1));
        stat_o.stop     = (row_reg >= h1);
        stat_o.drain_ok = (row_reg == h0) || (row_reg == h1);
        stat_o.fe_a     = (row_reg == h1);
        stat_o.var_done = var_done;
        stat_o.var_busy = var_busy;
        stat_o.out_free = !out_valid_reg || m_tready;
    end

    dlvf_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_line_a (
        .aclk  (aclk),
        .addr  (col_reg),
        .we    (cmd_i.load),
        .wdata (colv[2]),
        .rdata (rd_a)
    );

    dlvf_ram #(.WIDTH(DW), .DEPTH(MAX_WIDTH)) u_line_b (
        .aclk  (aclk),
        .addr  (col_reg),
        .we    (cmd_i.load),
        .wdata (wr_b),
        .rdata (rd_b)
    );

    // On the first row both stores take the new pixel, so the row above the
    // image repeats row 0.
    assign colv[0] = rd_b;
    assign colv[1] = rd_a;
    assign colv[2] = cmd_i.virt ? rd_a : depth_reg;
    assign wr_b    = (row_reg == '0) ? colv[2] : rd_a;

    assign depth_next = cmd_i.take ? DW'(depth_i) : depth_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            win_next[i] = win_reg[i];
        end
        if (cmd_i.shift) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r*3]   = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
        end else if (cmd_i.load) begin
            for (int r = 0; r < 3; r++) begin
                if (col_reg == '0) begin
                    win_next[r*3]   = colv[r];
                    win_next[r*3+1] = colv[r];
                end else begin
                    win_next[r*3]   = win_reg[r*3+1];
                    win_next[r*3+1] = win_reg[r*3+2];
                end
                win_next[r*3+2] = colv[r];
            end
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (pos_clear_i) begin
            col_next = '0;
            row_next = '0;
        end else if (cmd_i.take && !cmd_i.virt && (row_reg >= h0)) begin
            col_next = '0;
            row_next = '0;
        end else if (cmd_i.park) begin
            col_next = '0;
            row_next = h2;
        end else if (cmd_i.adv) begin
            if (CW1'(col_reg) + CW1'(1) >= eff_w) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    dlvf_var #(.DEPTH_BITS(DW)) u_var (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (cmd_i.var_start),
        .win_i    (win_reg),
        .gain_i   (gain_i),
        .busy_o   (var_busy),
        .done_o   (var_done),
        .result_o (var_result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_var_next   = out_var_reg;
        out_fe_next    = out_fe_reg;
        out_last_next  = out_last_reg;
        if (cmd_i.out_load) begin
            out_valid_next = 1'b1;
            out_var_next   = var_result;
            out_fe_next    = cmd_i.out_fe;
            out_last_next  = cmd_i.out_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
        depth_reg    <= depth_next;
        out_var_reg  <= out_var_next;
        out_fe_reg   <= out_fe_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < 9; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_var_reg);
    assign m_tlast  = out_fe_reg;
    assign m_tuser  = out_last_reg;

endmodule

[rtl/dlvf_ctrl.sv]
`timescale 1ns / 1ps

module dlvf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 in_mode,
    input  dlvf_pkg::dlvf_stat_t stat_i,
    output dlvf_pkg::dlvf_cmd_t  cmd_o
);

    import dlvf_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_CHECK  = 11'b000_0000_0010,
        ST_A_GO   = 11'b000_0000_0100,
        ST_A_WAIT = 11'b000_0000_1000,
        ST_A_OUT  = 11'b000_0001_0000,
        ST_RD     = 11'b000_0010_0000,
        ST_LD     = 11'b000_0100_0000,
        ST_B_GO   = 11'b000_1000_0000,
        ST_B_WAIT = 11'b001_0000_0000,
        ST_B_OUT  = 11'b010_0000_0000,
        ST_ADV    = 11'b100_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic       mode_reg, mode_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd_o      = '0;
        cmd_o.virt = mode_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd_o.virt = in_mode;
                if (s_tvalid) begin
                    cmd_o.take = 1'b1;
                    mode_next  = in_mode;
                    cnt_next   = '0;
                    // A drain beat outside the drain rows is dropped.
                    if (!in_mode || stat_i.drain_ok) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (stat_i.need_a) begin
                    cmd_o.shift = 1'b1;
                    state_next  = ST_A_GO;
                end else if (stat_i.stop) begin
                    cmd_o.park = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_A_GO: begin
                cmd_o.var_start = 1'b1;
                state_next      = ST_A_WAIT;
            end
            ST_A_WAIT: begin
                if (stat_i.var_done) begin
                    state_next = ST_A_OUT;
                end
            end
            ST_A_OUT: begin
                if (stat_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    cmd_o.out_fe   = stat_i.fe_a;
                    cmd_o.out_last = !mode_reg || (cnt_reg == 2'd1) || stat_i.fe_a;
                    cnt_next       = cnt_reg + 2'd1;
                    if (stat_i.stop) begin
                        cmd_o.park = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_LD;
            end
            ST_LD: begin
                cmd_o.load = 1'b1;
                state_next = stat_i.need_b ? ST_B_GO : ST_ADV;
            end
            ST_B_GO: begin
                cmd_o.var_start = 1'b1;
                state_next      = ST_B_WAIT;
            end
            ST_B_WAIT: begin
                if (stat_i.var_done) begin
                    state_next = ST_B_OUT;
                end
            end
            ST_B_OUT: begin
                if (stat_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    cmd_o.out_last = !mode_reg || (cnt_reg == 2'd1);
                    cnt_next       = cnt_reg + 2'd1;
                    state_next     = ST_ADV;
                end
            end
            ST_ADV: begin
                cmd_o.adv = 1'b1;
                if (!mode_reg || (cnt_reg == 2'd2)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/depth_local_variance_filter_core.sv]
`timescale 1ns / 1ps
// A beat that gives a result waits for the variance unit, whose single shared multiplier
// forms nine squares and three further products in turn; a drain beat can give two results.
// Output lags input by one row and one pixel; drain beats flush the last row.
// aresetn is synchronous and clears position, control and registers to their defaults;
// the line stores are not cleared, as every entry is written on row 0 before it is read.
module depth_local_variance_filter_core #(
    parameter int unsigned MAX_WIDTH  = dlvf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned DEPTH_BITS = dlvf_pkg::DEPTH_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dlvf_pkg::DEPTH_W-1:0]     s_tdata,  // [15:0] depth
    input  logic [0:0]                       s_tuser,  // [0] mode (1 = drain)
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dlvf_pkg::OUT_TDATA_W-1:0] m_tdata,  // [41:0] variance_x256, rest zero
    output logic                             m_tlast,  // frame_end
    output logic [0:0]                       m_tuser,  // [0] run_last
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dlvf_pkg::PADDR_W-1:0]     paddr,
    input  logic [dlvf_pkg::PDATA_W-1:0]     pwdata,
    output logic [dlvf_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    import dlvf_pkg::*;

    logic [RWIDTH_W-1:0] row_width_reg, row_width_next;
    logic [RCOUNT_W-1:0] row_count_reg, row_count_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic                wr_en;
    logic [1:0]          reg_idx;
    logic                pos_clear;
    dlvf_cmd_t           cmd;
    dlvf_stat_t          stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        row_width_next = row_width_reg;
        row_count_next = row_count_reg;
        gain_next      = gain_reg;
        pos_clear      = 1'b0;
        if (wr_en) begin
            unique case (reg_idx)
                REG_ROW_WIDTH: begin
                    row_width_next = pwdata[RWIDTH_W-1:0];
                    pos_clear      = 1'b1;
                end
                REG_ROW_COUNT: begin
                    row_count_next = pwdata[RCOUNT_W-1:0];
                    pos_clear      = 1'b1;
                end
                REG_NOISE_GAIN: begin
                    gain_next = pwdata[GAIN_W-1:0];
                end
                default: begin
                    pos_clear = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROW_WIDTH:  prdata = PDATA_W'(row_width_reg);
            REG_ROW_COUNT:  prdata = PDATA_W'(row_count_reg);
            REG_NOISE_GAIN: prdata = PDATA_W'(gain_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RST;
            row_count_reg <= ROW_COUNT_RST;
            gain_reg      <= NOISE_GAIN_RST;
        end else begin
            row_width_reg <= row_width_next;
            row_count_reg <= row_count_next;
            gain_reg      <= gain_next;
        end
    end

    dlvf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (s_tuser[0]),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    dlvf_dp #(.MAX_WIDTH(MAX_WIDTH), .DEPTH_BITS(DEPTH_BITS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .row_width_i (row_width_reg),
        .row_count_i (row_count_reg),
        .gain_i      (gain_reg),
        .pos_clear_i (pos_clear),
        .depth_i     (s_tdata),
        .cmd_i       (cmd),
        .stat_o      (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // The frame's final result always closes the beat that caused it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end result not marked as last of its beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !stat.var_busy)
        else $error("input taken while the variance unit is busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result load did not reach the output register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.var_start |=> stat.var_busy)
        else $error("variance unit did not start");

endmodule

[tb/dlvf_checker.sv]
`timescale 1ns / 1ps

module dlvf_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [dlvf_pkg::DEPTH_W-1:0]     s_tdata,
    input  logic [0:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [dlvf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tlast,
    input  logic [0:0]                       m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dlvf_pkg::PADDR_W-1:0]     paddr,
    input  logic [dlvf_pkg::PDATA_W-1:0]     pwdata,
    input  logic                             pready,
    output int                               fail_count,
    output int                               owed_count
);

    import dlvf_pkg::*;

    typedef struct {
        logic [VAR_W-1:0] variance;
        logic             frame_end;
        logic             run_last;
    } var_result_t;

    localparam int unsigned LINE_LEN = MAX_WIDTH_DEF;
    localparam int unsigned WEIGHT [NTAPS] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

    logic [DEPTH_W-1:0]  newer_row [LINE_LEN];
    logic [DEPTH_W-1:0]  older_row [LINE_LEN];
    logic [DEPTH_W-1:0]  win [NTAPS];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [RWIDTH_W-1:0] cfg_width;
    logic [RCOUNT_W-1:0] cfg_rows;
    logic [GAIN_W-1:0]   cfg_gain;
    var_result_t         owed_q [$];

    function automatic int unsigned width_eff();
        int unsigned w;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > LINE_LEN) w = LINE_LEN;
        return w;
    endfunction

    function automatic int unsigned rows_eff();
        return (cfg_rows == 0) ? 1 : cfg_rows;
    endfunction

    function automatic logic [VAR_W-1:0] window_variance();
        longint unsigned s1, s2, hi, lo, g, noise;
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < NTAPS; i++) begin
            s1 += WEIGHT[i] * longint'(win[i]);
            s2 += WEIGHT[i] * longint'(win[i]) * longint'(win[i]);
        end
        g     = cfg_gain;
        hi    = s2 >> 32;
        lo    = s2 & 64'hFFFF_FFFF;
        noise = ((hi * g) << 4) + ((lo * g) >> NOISE_SHIFT);
        return VAR_W'(16 * s2 + noise - s1 * s1);
    endfunction

    function automatic void owe(logic fe);
        var_result_t r;
        r.variance  = window_variance();
        r.frame_end = fe;
        r.run_last  = 1'b0;
        owed_q.insert(owed_q.size(), r);
    endfunction

    // One real or virtual stream position.
    function automatic void advance(logic [DEPTH_W-1:0] d, logic virt);
        int unsigned w, h, ci;
        logic [DEPTH_W-1:0] colv [3];
        w = width_eff();
        h = rows_eff();
        if (col_pos == 0 && row_pos >= 2) begin
            for (int r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            owe(row_pos == h + 1);
        end
        if (row_pos >= h + 1) begin
            row_pos = h + 2;
            col_pos = 0;
            return;
        end
        ci = (col_pos >= LINE_LEN) ? LINE_LEN - 1 : col_pos;
        colv[0] = older_row[ci];
        colv[1] = newer_row[ci];
        colv[2] = virt ? colv[1] : d;
        for (int r = 0; r < 3; r++) begin
            if (col_pos == 0) begin
                win[r*3]   = colv[r];
                win[r*3+1] = colv[r];
            end else begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[r*3+2] = colv[r];
        end
        older_row[ci] = (row_pos == 0) ? colv[2] : colv[1];
        newer_row[ci] = colv[2];
        if (row_pos >= 1 && col_pos >= 1) owe(1'b0);
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
    endfunction

    function automatic void take_beat(logic drain, logic [DEPTH_W-1:0] d);
        int unsigned h, prev_count;
        h          = rows_eff();
        prev_count = owed_q.size();
        if (!drain) begin
            if (row_pos >= h) begin
                row_pos = 0;
                col_pos = 0;
            end
            advance(d, 1'b0);
        end else if (row_pos >= h && row_pos <= h + 1) begin
            while (owed_q.size() - prev_count < 2 && row_pos <= h + 1) advance('0, 1'b1);
        end
        if (owed_q.size() > prev_count) owed_q[owed_q.size()-1].run_last = 1'b1;
    endfunction

    always @(posedge aclk) begin
        var_result_t e;
        if (!aresetn) begin
            for (int i = 0; i < LINE_LEN; i++) begin
                newer_row[i] = '0;
                older_row[i] = '0;
            end
            for (int i = 0; i < NTAPS; i++) win[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            cfg_width  = ROW_WIDTH_RST;
            cfg_rows   = ROW_COUNT_RST;
            cfg_gain   = NOISE_GAIN_RST;
            fail_count = 0;
            owed_q.delete();
            owed_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ROW_WIDTH: begin
                        cfg_width = pwdata[RWIDTH_W-1:0];
                        row_pos   = 0;
                        col_pos   = 0;
                    end
                    REG_ROW_COUNT: begin
                        cfg_rows = pwdata[RCOUNT_W-1:0];
                        row_pos  = 0;
                        col_pos  = 0;
                    end
                    REG_NOISE_GAIN: cfg_gain = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) take_beat(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) begin
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected result beat, actual var=%0d fe=%0b last=%0b",
                             $time, m_tdata, m_tlast, m_tuser[0]);
                    fail_count++;
                end else begin
                    e = owed_q.pop_front();
                    if (m_tdata !== OUT_TDATA_W'(e.variance) || m_tlast !== e.frame_end
                            || m_tuser[0] !== e.run_last) begin
                        $display("%0t: mismatch exp var=%0d fe=%0b last=%0b",
                                 $time, e.variance, e.frame_end, e.run_last);
                        $display("%0t:          got var=%0d fe=%0b last=%0b",
                                 $time, m_tdata, m_tlast, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            owed_count = owed_q.size();
        end
    end

endmodule

[tb/tb_depth_local_variance_filter_core.sv]
`timescale 1ns / 1ps

module tb_depth_local_variance_filter_core;
    import dlvf_pkg::*;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DEPTH_W-1:0]     s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [0:0]             m_tuser;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [PDATA_W-1:0]     pwdata   = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    int                     fail_count;
    int                     owed_count;
    int                     beats_sent = 0;
    bit                     calm       = 0;
    bit                     squeeze    = 0;

    localparam int RANDOM_BEATS = 460;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    depth_local_variance_filter_core dut (.*);

    dlvf_checker chk (.*);

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        @(posedge aclk);
        forever begin
            if (squeeze) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                squeeze = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_beat(logic drain, logic [DEPTH_W-1:0] d);
        s_tvalid   <= 1'b1;
        s_tuser[0] <= drain;
        s_tdata    <= d;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers may only change once the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (owed_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [DEPTH_W-1:0] pick_depth();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return PDATA_W'(24'hFF_FFFF);
            default: return PDATA_W'($urandom & 24'hFF_FFFF);
        endcase
    endfunction

    // Full frame of pixels with the odd stray drain beat, then a full, partial or no flush.
    task automatic run_frame(int unsigned w, int unsigned h, int unsigned flush);
        for (int unsigned i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 15) == 0) send_beat(1'b1, pick_depth());
            send_beat(1'b0, pick_depth());
        end
        case (flush)
            0: for (int unsigned i = 0; i < w / 2 + 3; i++) send_beat(1'b1, pick_depth());
            1: ;
            default: repeat ($urandom_range(1, 2)) send_beat(1'b1, pick_depth());
        endcase
    endtask

    initial begin
        int unsigned w, h, wr;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: small frame with extreme depths and full gain.
        reg_write(REG_ROW_WIDTH, 3);
        reg_write(REG_ROW_COUNT, 2);
        reg_write(REG_NOISE_GAIN, 32'h00FF_FFFF);
        reg_write(2'd3, 32'hFFFF_FFFF);
        send_beat(1'b0, '1);
        send_beat(1'b0, '0);
        send_beat(1'b1, '1);
        send_beat(1'b0, '1);
        send_beat(1'b0, '0);
        send_beat(1'b0, '1);
        send_beat(1'b0, '0);
        repeat (4) send_beat(1'b1, '0);
        // Pixel after a frame that was never drained starts the next one.
        run_frame(3, 2, 1);
        run_frame(3, 2, 0);
        settle();
        // Zero geometry acts as one pixel.
        reg_write(REG_ROW_WIDTH, 0);
        reg_write(REG_ROW_COUNT, 0);
        reg_write(REG_NOISE_GAIN, 0);
        run_frame(1, 1, 0);
        settle();
        // Widest row, abandoned by a geometry write part way through the first row.
        reg_write(REG_ROW_WIDTH, 32'hFFF);
        reg_write(REG_ROW_COUNT, 1);
        for (int i = 0; i < 40; i++) send_beat(1'b0, pick_depth());
        repeat (3) send_beat(1'b1, '0);
        settle();
        // Tallest frame count, abandoned after a few rows.
        reg_write(REG_ROW_WIDTH, 2);
        reg_write(REG_ROW_COUNT, 32'h1FFF);
        for (int i = 0; i < 8; i++) send_beat(1'b0, pick_depth());
        settle();

        beats_sent = 0;
        squeeze    = 1;
        w          = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent > RANDOM_BEATS - 80) calm = 1;
            if (w == 0 || (!calm && $urandom_range(0, 1) == 0)) begin
                settle();
                wr = $urandom_range(0, 9);
                w  = (wr == 0) ? 0 : (wr == 9) ? 12 : $urandom_range(1, 6);
                h  = $urandom_range(0, 4);
                reg_write(REG_ROW_WIDTH, w);
                reg_write(REG_ROW_COUNT, h);
                reg_write(REG_NOISE_GAIN, pick_gain());
                if (w == 0) w = 1;
                if (h == 0) h = 1;
            end
            run_frame(w, h, (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 2));
        end

        s_tvalid <= 1'b0;
        while (owed_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
